// ===== design/wsp_pkg.sv =====
// Shared types and constants for the wheel speed block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wsp_pkg;

  localparam int NUM_WHEELS_DEF = 4;
  localparam int STAMP_W        = 32;
  localparam int SPEED_W        = 16;
  localparam int WHEEL_W        = 2;
  // Wide enough to compare a wheel index against any wheel count up to 16.
  localparam int WSEL_W         = 5;
  localparam int CFG_W          = 32;
  localparam int CFG_ADDR_W     = 2;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 64;
  localparam int OUT_SPEEDS     = 4;
  // The queue depth must be a power of two so the pointers wrap by themselves.
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED_NUM   = 2'd0,
    REG_MIN_PERIOD  = 2'd1,
    REG_STALE_COUNT = 2'd2
  } wsp_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } wsp_state_t;

  // One classified event as it waits between the front and the back.
  typedef struct packed {
    logic                 is_timeout;
    logic                 wheel_ok;
    logic [WHEEL_W-1:0]   wheel;
    logic [STAMP_W-1:0]   stamp;
  } wsp_item_t;

endpackage

`default_nettype wire

// ===== design/wheel_speed_from_tooth_period.sv =====
// Wheel speed from tooth period: measures up to NUM_WHEELS wheel speeds from tooth edges.
// Top level; depends on wsp_pkg, wsp_front and wsp_back.
//
// Input beats carry either a tooth edge (in_tuser = 0, wheel index and a 32-bit timer
// capture in in_tdata) or a timeout (in_tuser = 1, which zeroes every speed).
// Each input beat produces exactly one output beat holding all four speeds in tenths
// of km/h and, in out_tuser, whether this edge stored a new speed.
// The cfg port writes speed_numerator, min_period and stale_count; write it only
// while no event is in flight.
// An edge that passes the period test goes through a one-bit-per-cycle 32-step
// divider: out_tvalid rises once the event has been popped, checked, divided in
// 32 steps and its result registered. Timeouts and discarded edges raise it after
// the pop and check states only. Events are executed one at a time, and the
// next one is popped the cycle after the beat is taken. A two-entry queue keeps
// accepting events while one is in the divider or its result waits. If the
// receiver stalls, the result holds on out_tdata and the next event stays queued
// until the beat is taken; in_tready falls once the queue is full.
// Reset (rst_n low, synchronous) clears the queue, all speeds and captures, and
// loads the register defaults; no output beat is pending afterwards.
`default_nettype none

module wheel_speed_from_tooth_period
  import wsp_pkg::*;
#(
  parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] wheel, [33:2] timestamp, [39:34] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  wire logic                   in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [15:0] speed_a, [31:16] speed_b, [47:32] speed_c, [63:48] speed_d
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [0] updated
  output logic                        out_tuser
);

  logic      q_valid;
  logic      q_pop;
  wsp_item_t q_item;

  wsp_front #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wsp_back #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== design/wsp_front.sv =====
// Input side: accepts event beats, classifies them and holds them in a short queue.
// Depends on wsp_pkg.
`default_nettype none

module wsp_front
  import wsp_pkg::*;
#(
  parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  output logic                       q_valid,
  output wsp_item_t                  q_item,
  input  wire logic                  q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wsp_item_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  wsp_item_t           item_in;
  logic                push;

  always_comb begin
    item_in.is_timeout = in_tuser;
    item_in.wheel      = in_tdata[WHEEL_W-1:0];
    item_in.stamp      = in_tdata[WHEEL_W +: STAMP_W];
    item_in.wheel_ok   = ({{(WSEL_W-WHEEL_W){1'b0}}, item_in.wheel} < WSEL_W'(NUM_WHEELS));
  end

  assign in_tready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, q_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/wsp_div.sv =====
// Restoring 32-by-32 unsigned divider, one quotient bit per cycle.
// Depends on wsp_pkg; the divisor must be nonzero at start.
`default_nettype none

module wsp_div
  import wsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [STAMP_W-1:0] dividend,
  input  wire logic [STAMP_W-1:0] divisor,
  output logic                    done,
  output logic [STAMP_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(STAMP_W + 1);

  logic [STAMP_W-1:0] rem_r, quo_r, den_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic [STAMP_W:0]   trial;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial    = {rem_r, quo_r[STAMP_W-1]} - {1'b0, den_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!trial[STAMP_W]) begin
        rem_r <= trial[STAMP_W-1:0];
        quo_r <= {quo_r[STAMP_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[STAMP_W-2:0], quo_r[STAMP_W-1]};
        quo_r <= {quo_r[STAMP_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STAMP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/wsp_back.sv =====
// Execution side: per-wheel state, stale check, period test, division and result beat.
// Depends on wsp_pkg and wsp_div.
`default_nettype none

module wsp_back
  import wsp_pkg::*;
#(
  parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   q_valid,
  input  wsp_item_t                   q_item,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser
);

  logic [STAMP_W-1:0] speed_num_r, min_period_r, stale_count_r;

  wsp_state_t         state_r, state_nxt;
  wsp_item_t          item_r;
  logic [SPEED_W-1:0] speed_r   [NUM_WHEELS];
  logic [SPEED_W-1:0] speed_nxt [NUM_WHEELS];
  logic [STAMP_W-1:0] stamp_r   [NUM_WHEELS];
  logic [STAMP_W-1:0] stamp_nxt [NUM_WHEELS];
  logic               out_valid_r, out_valid_nxt;
  logic               updated_r, updated_nxt;

  logic [NUM_WHEELS-1:0] sel;
  logic [NUM_WHEELS-1:0] stale;
  logic [STAMP_W-1:0]    sel_stamp;
  logic [STAMP_W-1:0]    period;
  logic                  take;
  logic                  div_start, div_done;
  logic [STAMP_W-1:0]    div_quo;
  logic [SPEED_W-1:0]    speed_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_num_r   <= '0;
      min_period_r  <= '0;
      stale_count_r <= '1;
    end else if (cfg_we) begin
      unique case (wsp_reg_t'(cfg_addr))
        REG_SPEED_NUM:   speed_num_r   <= cfg_wdata;
        REG_MIN_PERIOD:  min_period_r  <= cfg_wdata;
        REG_STALE_COUNT: stale_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ages of all wheels are checked side by side; the chosen wheel's capture is muxed out.
  always_comb begin
    sel_stamp = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      sel[i]   = item_r.wheel_ok &&
                 ({{(WSEL_W-WHEEL_W){1'b0}}, item_r.wheel} == WSEL_W'(i));
      stale[i] = ((item_r.stamp - stamp_r[i]) > stale_count_r);
      if (sel[i]) begin
        sel_stamp = stamp_r[i];
      end
    end
    period = item_r.stamp - sel_stamp;
    take   = item_r.wheel_ok && (period != '0) && (period >= min_period_r);
  end

  assign speed_sat = (div_quo[STAMP_W-1:SPEED_W] != '0) ? '1 : div_quo[SPEED_W-1:0];

  wsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (speed_num_r),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    updated_nxt   = updated_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // The speeds drive the result directly, so nothing moves until it is taken.
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (item_r.is_timeout) begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            speed_nxt[i] = '0;
          end
          out_valid_nxt = 1'b1;
          updated_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            if (stale[i]) begin
              speed_nxt[i] = '0;
            end
          end
          if (take) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            updated_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            if (sel[i]) begin
              speed_nxt[i] = speed_sat;
              stamp_nxt[i] = item_r.stamp;
            end
          end
          out_valid_nxt = 1'b1;
          updated_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    updated_r <= updated_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        speed_r[i] <= '0;
        stamp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      speed_r     <= speed_nxt;
      stamp_r     <= stamp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = updated_r;

  for (genvar g = 0; g < OUT_SPEEDS; g++) begin : g_out
    if (g < NUM_WHEELS) begin : g_used
      assign out_tdata[g*SPEED_W +: SPEED_W] = speed_r[g];
    end else begin : g_unused
      assign out_tdata[g*SPEED_W +: SPEED_W] = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/wsp_checker.sv =====
// Port-level checks for the wheel speed block, bound to the top level.
// Depends on wsp_pkg.
`default_nettype none

module wsp_checker
  import wsp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Each event needs a pop and a check cycle, so results never come back to back.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result beats in consecutive cycles");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind wheel_speed_from_tooth_period wsp_checker u_wsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
